// ===== src/idle_gap_frame_receiver_assert.svh =====
// Assertion macros shared by the receiver.
`ifndef IDLE_GAP_FRAME_RECEIVER_ASSERT_SVH
`define IDLE_GAP_FRAME_RECEIVER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define IGFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define IGFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/igfr_pkg.sv =====
package igfr_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam logic [7:0] IDLE_TICKS_RESET = 8'd10;
    localparam logic [7:0] IDLE_MAX = 8'hFF;
    localparam int LEN_W = 5;

    typedef enum logic [1:0]
    {
        REQ_BYTE = 2'd0,
        REQ_TICK = 2'd1,
        REQ_READ = 2'd2
    } req_t;

    typedef enum logic
    {
        ST_IDLE   = 1'b0,
        ST_STREAM = 1'b1
    } state_t;

endpackage

// ===== src/idle_gap_frame_receiver.sv =====
// Idle-gap frame receiver. Received bytes (req_type 0) are written into a
// DEPTH-entry synchronous frame store; timer ticks (req_type 1) advance an
// idle counter that saturates at 255, and a byte clears it. Once the counter
// reaches the idle_ticks register with at least one byte held, the frame is
// complete. A read (req_type 2) of a complete frame of n bytes returns n
// items in order, each with frame_ready set, the length and the overflow
// flag, the final one marked by last, and empties the buffer; a read with no
// complete frame returns one item with frame_ready low and last high.
// Bytes beyond DEPTH are dropped and reported through overflowed. Byte, tick
// and unused-code items complete when accepted. A read of a frame streams its
// bytes at one per cycle while out_ready is high, through the store's single
// read port; the first result passes through the state register, the store's
// read register and the output register. No new item is accepted until the
// last result of the read has been taken. The store is never cleared, since a
// read only returns entries written into the current frame. idle_ticks may be
// written at any time the block is idle through cfg_we and cfg_wdata.
module idle_gap_frame_receiver #(
    parameter int DEPTH = igfr_pkg::DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] rx_byte,

    output logic       out_valid,
    input  logic       out_ready,
    output logic       frame_ready,
    output logic [7:0] data,
    output logic       last,
    output logic [4:0] length,
    output logic       overflowed
);

    `include "idle_gap_frame_receiver_assert.svh"

    // Address width of the store and width of a count that can hold DEPTH.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    igfr_pkg::state_t state_reg, state_next;

    logic [7:0]    idle_ticks_reg;
    logic [CW-1:0] fill_count_reg, fill_count_next;
    logic [7:0]    idle_counter_reg, idle_counter_next;
    logic          frame_done_reg, frame_done_next;
    logic          drop_flag_reg, drop_flag_next;

    // Frame being streamed: its length, overflow flag and read position.
    logic [CW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] issue_cnt_reg, issue_cnt_next;

    // The store's read register holds a fetched byte until the output takes it.
    logic          pend_reg, pend_next;
    logic          pend_last_reg, pend_last_next;
    logic [7:0]    rd_data_reg;

    logic          out_valid_reg, out_valid_next;
    logic          out_frame_ready_reg;
    logic [7:0]    out_data_reg;
    logic          out_last_reg;
    logic [4:0]    out_length_reg;
    logic          out_overflowed_reg;

    logic [7:0]    frame_store_mem [DEPTH];

    logic          accept;
    logic          start;
    logic          nack;
    logic          wr_en;
    logic          issue;
    logic          move;
    logic          out_free;
    logic [7:0]    idle_inc;
    logic [CW+4:0] len_ext;

    igfr_pkg::req_t req;

    assign req      = igfr_pkg::req_t'(req_type);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign move     = pend_reg && out_free;
    assign len_ext  = {5'b0, len_reg};
    assign idle_inc = (idle_counter_reg != igfr_pkg::IDLE_MAX) ?
                      idle_counter_reg + 8'd1 : idle_counter_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            igfr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = igfr_pkg::ST_STREAM;
                end
            end
            igfr_pkg::ST_STREAM:
            begin
                if (move && pend_last_reg)
                begin
                    state_next = igfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = igfr_pkg::ST_IDLE;
            end
        endcase
    end

    // State machine outputs: input handshake and store read issue.
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        unique case (state_reg)
            igfr_pkg::ST_IDLE:
            begin
                in_ready = out_free;
            end
            igfr_pkg::ST_STREAM:
            begin
                issue = (issue_cnt_reg < len_reg) && (!pend_reg || move);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Item decode and frame bookkeeping.
    always_comb
    begin
        fill_count_next   = fill_count_reg;
        idle_counter_next = idle_counter_reg;
        frame_done_next   = frame_done_reg;
        drop_flag_next    = drop_flag_reg;
        len_next          = len_reg;
        ovf_next          = ovf_reg;
        issue_cnt_next    = issue_cnt_reg;
        start             = 1'b0;
        nack              = 1'b0;
        wr_en             = 1'b0;

        if (accept)
        begin
            unique case (req)
                igfr_pkg::REQ_BYTE:
                begin
                    if (fill_count_reg < CW'(DEPTH))
                    begin
                        wr_en           = 1'b1;
                        fill_count_next = fill_count_reg + CW'(1);
                    end
                    else
                    begin
                        drop_flag_next = 1'b1;
                    end
                    idle_counter_next = 8'd0;
                end
                igfr_pkg::REQ_TICK:
                begin
                    idle_counter_next = idle_inc;
                    if ((fill_count_reg != '0) && (idle_inc >= idle_ticks_reg))
                    begin
                        frame_done_next = 1'b1;
                    end
                end
                igfr_pkg::REQ_READ:
                begin
                    if (frame_done_reg && (fill_count_reg != '0))
                    begin
                        start           = 1'b1;
                        len_next        = fill_count_reg;
                        ovf_next        = drop_flag_reg;
                        issue_cnt_next  = '0;
                        fill_count_next = '0;
                        frame_done_next = 1'b0;
                        drop_flag_next  = 1'b0;
                    end
                    else
                    begin
                        nack = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (issue)
        begin
            issue_cnt_next = issue_cnt_reg + CW'(1);
        end
    end

    // Read register tracking and output register occupancy.
    always_comb
    begin
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (issue)
        begin
            pend_next      = 1'b1;
            pend_last_next = (issue_cnt_reg + CW'(1)) == len_reg;
        end
        else if (move)
        begin
            pend_next = 1'b0;
        end
        if (move || nack)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= igfr_pkg::ST_IDLE;
            idle_ticks_reg   <= igfr_pkg::IDLE_TICKS_RESET;
            fill_count_reg   <= '0;
            idle_counter_reg <= 8'd0;
            frame_done_reg   <= 1'b0;
            drop_flag_reg    <= 1'b0;
            len_reg          <= '0;
            ovf_reg          <= 1'b0;
            issue_cnt_reg    <= '0;
            pend_reg         <= 1'b0;
            pend_last_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            if (cfg_we)
            begin
                idle_ticks_reg <= cfg_wdata;
            end
            fill_count_reg   <= fill_count_next;
            idle_counter_reg <= idle_counter_next;
            frame_done_reg   <= frame_done_next;
            drop_flag_reg    <= drop_flag_next;
            len_reg          <= len_next;
            ovf_reg          <= ovf_next;
            issue_cnt_reg    <= issue_cnt_next;
            pend_reg         <= pend_next;
            pend_last_reg    <= pend_last_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Frame store: one write port at the fill position, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_store_mem[fill_count_reg[AW-1:0]] <= rx_byte;
        end
        if (issue)
        begin
            rd_data_reg <= frame_store_mem[issue_cnt_reg[AW-1:0]];
        end
    end

    // Output payload: a streamed byte, or the nothing-ready item.
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_frame_ready_reg <= 1'b1;
            out_data_reg        <= rd_data_reg;
            out_last_reg        <= pend_last_reg;
            out_length_reg      <= len_ext[4:0];
            out_overflowed_reg  <= ovf_reg;
        end
        else if (nack)
        begin
            out_frame_ready_reg <= 1'b0;
            out_data_reg        <= 8'd0;
            out_last_reg        <= 1'b1;
            out_length_reg      <= 5'd0;
            out_overflowed_reg  <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_ready = out_frame_ready_reg;
    assign data        = out_data_reg;
    assign last        = out_last_reg;
    assign length      = out_length_reg;
    assign overflowed  = out_overflowed_reg;

    // A completed frame always holds at least one byte.
    `IGFR_ASSERT_SAME(a_done_has_bytes, clk, rst_n, frame_done_reg, fill_count_reg != '0)
    // Reads never run past the latched frame length.
    `IGFR_ASSERT_SAME(a_issue_in_range, clk, rst_n, issue, issue_cnt_reg < len_reg)
    // No byte can enter the buffer while a frame is streaming out.
    `IGFR_ASSERT_SAME(a_stream_no_fill, clk, rst_n, state_reg == igfr_pkg::ST_STREAM, !wr_en)
    // Handing over the final byte returns the block to idle.
    `IGFR_ASSERT_NEXT(a_last_ends_stream, clk, rst_n, move && pend_last_reg,
                      state_reg == igfr_pkg::ST_IDLE && !pend_reg)

endmodule
